### design/arlt_pkg.sv
// Shared constants and types for the address range lookup table.
package arlt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TAG_BITS    = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int GRP_SIZE    = 16;
	localparam int GRP_NUM     = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [63:0] SYM_SIZED_SLACK   = 64'h1000;
	localparam logic [63:0] SYM_UNSIZED_SLACK = 64'h10000;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic REG_STRICT_BOUNDS = 1'b0;
	localparam logic REG_ADDRESS_BIAS  = 1'b1;

	typedef logic [TAG_BITS-1:0] tag_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	typedef struct packed {
		logic [63:0] start;
		logic [63:0] length;
		tag_t        tag;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic sel;
	} cell_ctl_t;

endpackage

### design/address_range_lookup_table_unit.sv
// Top level of the address range lookup table.
//
//  group   | dir | payload
//  s_axis  | in  | tuser: func; tdata: addr, range_size, entry_tag
//  m_axis  | out | tuser: hit, table_full; tdata: found_tag, offset
//  cfg     | in  | cfg_we, cfg_index, cfg_data (64 bits)
//
// An insert compares in every cell, then shifts the new entry in; one refused
// as full goes straight to the result. A lookup passes compare in every cell,
// per-cell select, two levels of OR tree, offset subtract, bounds check into
// the output register. s_axis_tready returns as m_axis_tvalid rises.
// One item is in work at a time; the next is taken while a result waits.
// The final state holds while m_axis is stalled.
// Reset empties the table and clears both registers.
module address_range_lookup_table_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // addr[63:0], range_size[127:64], entry_tag[143:128]
	input  logic         s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [79:0]  m_axis_tdata,  // found_tag[15:0], offset[79:16]
	output logic [1:0]   m_axis_tuser,  // hit[0], table_full[1]
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_CMP, S_INS, S_SEL, S_GRP, S_PICK, S_OFFS, S_DONE
	} state_t;

	state_t              state_q;
	logic                strict_q;
	logic [63:0]         bias_q;
	arlt_pkg::cnt_t      count_q;
	logic                func_q;
	logic                full_q;
	logic [63:0]         key_q;
	arlt_pkg::entry_t    new_q;
	arlt_pkg::entry_t    pick_q;
	logic                found_q;
	logic [63:0]         off_q;
	logic [63:0]         len_q;
	arlt_pkg::tag_t      tag_q;
	logic                m_valid_q;
	logic [79:0]         m_data_q;
	logic [1:0]          m_user_q;

	arlt_pkg::cell_ctl_t ctl;
	logic                found_w;
	arlt_pkg::entry_t    picked_w;
	logic [63:0]         in_addr;
	logic                ok;
	logic                done_fire;

	assign in_addr   = s_axis_tdata[63:0];
	assign ctl.cmp   = (state_q == S_CMP);
	assign ctl.ins   = (state_q == S_INS);
	assign ctl.sel   = (state_q == S_SEL);
	assign done_fire = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	arlt_array u_array (
		.clk       (clk),
		.ctl       (ctl),
		.count     (count_q),
		.key       (key_q),
		.new_entry (new_q),
		.found     (found_w),
		.picked    (picked_w)
	);

	always_comb begin
		if (strict_q) begin
			ok = off_q < len_q;
		end else if (len_q != 64'd0) begin
			ok = (off_q < len_q) || (off_q <= arlt_pkg::SYM_SIZED_SLACK);
		end else begin
			ok = off_q <= arlt_pkg::SYM_UNSIZED_SLACK;
		end
		ok = ok && found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			strict_q  <= 1'b0;
			bias_q    <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					arlt_pkg::REG_STRICT_BOUNDS: strict_q <= cfg_data[0];
					arlt_pkg::REG_ADDRESS_BIAS:  bias_q   <= cfg_data;
					default:                     ;
				endcase
			end
			if (done_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						func_q <= s_axis_tuser;
						full_q <= 1'b0;
						if (s_axis_tuser == arlt_pkg::FUNC_LOOKUP) begin
							key_q   <= in_addr;
							state_q <= S_CMP;
						end else begin
							key_q        <= in_addr + bias_q;
							new_q.start  <= in_addr + bias_q;
							new_q.length <= s_axis_tdata[127:64];
							new_q.tag    <= arlt_pkg::tag_t'(s_axis_tdata[143:128]);
							if (count_q == arlt_pkg::cnt_t'(arlt_pkg::TABLE_DEPTH)) begin
								full_q  <= 1'b1;
								state_q <= S_DONE;
							end else begin
								state_q <= S_CMP;
							end
						end
					end
				end
				S_CMP: begin
					state_q <= (func_q == arlt_pkg::FUNC_LOOKUP) ? S_SEL : S_INS;
				end
				S_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= S_DONE;
				end
				S_SEL: state_q <= S_GRP;
				S_GRP: state_q <= S_PICK;
				S_PICK: begin
					pick_q  <= picked_w;
					found_q <= found_w;
					state_q <= S_OFFS;
				end
				S_OFFS: begin
					off_q   <= key_q - pick_q.start;
					len_q   <= pick_q.length;
					tag_q   <= pick_q.tag;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						if (func_q == arlt_pkg::FUNC_LOOKUP) begin
							m_data_q <= ok ? {off_q, 16'(tag_q)} : '0;
							m_user_q <= {1'b0, ok};
						end else begin
							m_data_q <= '0;
							m_user_q <= {full_q, 1'b0};
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= arlt_pkg::cnt_t'(arlt_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");

	a_full_only_at_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && full_q
		|-> count_q == arlt_pkg::cnt_t'(arlt_pkg::TABLE_DEPTH))
		else $error("insert refused while room remains");

	a_hit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_user_q[0] && m_user_q[1]))
		else $error("result flags both hit and full");

	a_empty_no_find: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEL && count_q == '0 |-> !found_w)
		else $error("lookup found an entry in an empty table");

endmodule

### design/arlt_cell.sv
// One table entry: compares its start, shifts on insert, offers itself on lookup.
module arlt_cell (
	input  logic                clk,
	input  arlt_pkg::cell_ctl_t ctl,
	input  logic                valid,
	input  logic [63:0]         key,
	input  logic                prev_le,
	input  logic                next_le,
	input  arlt_pkg::entry_t    new_entry,
	input  arlt_pkg::entry_t    prev_entry,
	output logic                le,
	output arlt_pkg::entry_t    entry,
	output arlt_pkg::entry_t    contrib
);

	logic             le_q;
	arlt_pkg::entry_t entry_q;
	arlt_pkg::entry_t contrib_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			le_q <= valid && (entry_q.start <= key);
		end
		if (ctl.ins && !le_q) begin
			if (prev_le) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= prev_entry;
			end
		end
		if (ctl.sel) begin
			contrib_q <= (le_q && !next_le) ? entry_q : '0;
		end
	end

	assign le      = le_q;
	assign entry   = entry_q;
	assign contrib = contrib_q;

endmodule

### design/arlt_array.sv
// Row of entry cells with a registered OR tree that gathers the selected entry.
module arlt_array (
	input  logic                clk,
	input  arlt_pkg::cell_ctl_t ctl,
	input  arlt_pkg::cnt_t      count,
	input  logic [63:0]         key,
	input  arlt_pkg::entry_t    new_entry,
	output logic                found,
	output arlt_pkg::entry_t    picked
);

	logic             le_w      [arlt_pkg::TABLE_DEPTH];
	arlt_pkg::entry_t entry_w   [arlt_pkg::TABLE_DEPTH];
	arlt_pkg::entry_t contrib_w [arlt_pkg::TABLE_DEPTH];
	arlt_pkg::entry_t grp_d     [arlt_pkg::GRP_NUM];
	arlt_pkg::entry_t grp_q     [arlt_pkg::GRP_NUM];

	for (genvar i = 0; i < arlt_pkg::TABLE_DEPTH; i++) begin : g_cell
		logic             prev_le_w;
		logic             next_le_w;
		arlt_pkg::entry_t prev_entry_w;

		if (i == 0) begin : g_first
			assign prev_le_w    = 1'b1;
			assign prev_entry_w = new_entry;
		end else begin : g_mid
			assign prev_le_w    = le_w[i-1];
			assign prev_entry_w = entry_w[i-1];
		end

		if (i == arlt_pkg::TABLE_DEPTH - 1) begin : g_last
			assign next_le_w = 1'b0;
		end else begin : g_next
			assign next_le_w = le_w[i+1];
		end

		arlt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (arlt_pkg::cnt_t'(i) < count),
			.key        (key),
			.prev_le    (prev_le_w),
			.next_le    (next_le_w),
			.new_entry  (new_entry),
			.prev_entry (prev_entry_w),
			.le         (le_w[i]),
			.entry      (entry_w[i]),
			.contrib    (contrib_w[i])
		);
	end

	always_comb begin
		for (int g = 0; g < arlt_pkg::GRP_NUM; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < arlt_pkg::GRP_SIZE; j++) begin
				if (g * arlt_pkg::GRP_SIZE + j < arlt_pkg::TABLE_DEPTH) begin
					grp_d[g] = grp_d[g] | contrib_w[g * arlt_pkg::GRP_SIZE + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_q <= grp_d;
	end

	always_comb begin
		picked = '0;
		for (int g = 0; g < arlt_pkg::GRP_NUM; g++) begin
			picked = picked | grp_q[g];
		end
	end

	// table is sorted, so any start at or below the key means the first one is
	assign found = le_w[0];

endmodule
